// ----- hdl/prot_pkg.sv -----
// Package with the types, constants and arithmetic helpers of the point rotator.
package prot_pkg;

    localparam int COORD_WIDTH    = 16;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int REG_WIDTH      = 16;
    localparam int REG_COUNT      = 7;
    localparam int CFG_IDX_W      = $clog2(REG_COUNT);
    localparam int INNER_FRAC     = 8;
    localparam int INNER_W        = 47;
    localparam int COEF_W         = REG_WIDTH + 1;
    localparam int LO_W           = 24;
    localparam int HI_W           = INNER_W - LO_W;
    localparam int PLO_W          = LO_W + 1 + COEF_W;
    localparam int PHI_W          = HI_W + COEF_W;
    localparam int SUM_W          = INNER_W + COEF_W + 2;
    localparam int ZPROD_W        = COORD_WIDTH + REG_WIDTH;

    localparam logic signed [REG_WIDTH-1:0] COS_RESET    = 16'sd16384;
    localparam logic signed [REG_WIDTH-1:0] SIN_RESET    = 16'sd0;
    localparam logic signed [REG_WIDTH-1:0] HEIGHT_RESET = 16'sd256;

    localparam logic signed [63:0] INNER_MAX64 = (64'sd1 <<< (INNER_W - 1)) - 64'sd1;
    localparam logic signed [SUM_W-1:0] SUM_INNER_MAX = SUM_W'(INNER_MAX64);
    localparam logic signed [SUM_W-1:0] SUM_INNER_MIN = -SUM_INNER_MAX - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] TRIG_HALF =
        SUM_W'(64'sd1 <<< (TRIG_FRAC_BITS - 1));

    localparam logic signed [INNER_W:0] OUT_HALF =
        (INNER_W + 1)'(64'sd1 <<< (INNER_FRAC - 1));
    localparam logic signed [INNER_W:0] OUT_MAX =
        (INNER_W + 1)'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [INNER_W:0] OUT_MIN = -OUT_MAX - (INNER_W + 1)'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_X  = 3'd0,
        REG_SIN_X  = 3'd1,
        REG_COS_Y  = 3'd2,
        REG_SIN_Y  = 3'd3,
        REG_COS_Z  = 3'd4,
        REG_SIN_Z  = 3'd5,
        REG_HEIGHT = 3'd6
    } t_reg_idx;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [INNER_W-1:0]     t_inner;
    typedef logic signed [COEF_W-1:0]      t_coef;

    typedef struct packed {
        t_coord in_x;
        t_coord in_y;
        t_coord in_z;
    } t_in_item;

    typedef struct packed {
        t_coord out_x;
        t_coord out_y;
        t_coord out_z;
    } t_out_item;

    typedef struct packed {
        t_inner a;
        t_inner b;
        t_inner pass;
    } t_rot_in;

    typedef struct packed {
        t_inner u;
        t_inner w;
        t_inner pass;
    } t_rot_out;

    typedef struct packed {
        logic mul;
        logic sum;
    } t_rot_en;

    function automatic t_inner clamp_inner(input logic signed [SUM_W-1:0] v);
        t_inner r;
        if (v > SUM_INNER_MAX) begin
            r = SUM_INNER_MAX[INNER_W-1:0];
        end else if (v < SUM_INNER_MIN) begin
            r = SUM_INNER_MIN[INNER_W-1:0];
        end else begin
            r = v[INNER_W-1:0];
        end
        return r;
    endfunction

    function automatic t_coord to_coord(input t_inner v);
        logic signed [INNER_W:0] r;
        t_coord o;
        r = ((INNER_W + 1)'(v) + OUT_HALF) >>> INNER_FRAC;
        if (r > OUT_MAX) begin
            o = OUT_MAX[COORD_WIDTH-1:0];
        end else if (r < OUT_MIN) begin
            o = OUT_MIN[COORD_WIDTH-1:0];
        end else begin
            o = r[COORD_WIDTH-1:0];
        end
        return o;
    endfunction

endpackage

// ----- hdl/prot_rot.sv -----
// One plane rotation: a registered partial-product stage and a registered sum stage.
module prot_rot (
    input  logic               i_clk,
    input  prot_pkg::t_rot_en  i_en,
    input  prot_pkg::t_rot_in  i_data,
    input  prot_pkg::t_coef    i_cos,
    input  prot_pkg::t_coef    i_sin,
    output prot_pkg::t_rot_out o_data
);
    import prot_pkg::*;

    typedef struct packed {
        logic signed [PHI_W-1:0] hi;
        logic signed [PLO_W-1:0] lo;
    } t_part;

    function automatic t_part mul_split(input t_inner v, input t_coef k);
        logic signed [LO_W:0]   lo_v;
        logic signed [HI_W-1:0] hi_v;
        t_part p;
        lo_v = $signed({1'b0, v[LO_W-1:0]});
        hi_v = v[INNER_W-1:LO_W];
        p.hi = hi_v * k;
        p.lo = lo_v * k;
        return p;
    endfunction

    function automatic logic signed [SUM_W-1:0] widen(input t_part p);
        return (SUM_W'(p.hi) <<< LO_W) + SUM_W'(p.lo);
    endfunction

    t_coef    neg_sin;
    t_part    r_ac, r_bs, r_ans, r_bc;
    t_inner   r_pass;
    t_rot_out r_out;
    t_rot_out n_out;
    logic signed [SUM_W-1:0] sum_u, sum_w;

    assign neg_sin = -i_sin;

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_ac   <= mul_split(i_data.a, i_cos);
            r_bs   <= mul_split(i_data.b, i_sin);
            r_ans  <= mul_split(i_data.a, neg_sin);
            r_bc   <= mul_split(i_data.b, i_cos);
            r_pass <= i_data.pass;
        end
    end

    always_comb begin
        sum_u      = widen(r_ac) + widen(r_bs) + TRIG_HALF;
        sum_w      = widen(r_ans) + widen(r_bc) + TRIG_HALF;
        n_out.u    = clamp_inner(sum_u >>> TRIG_FRAC_BITS);
        n_out.w    = clamp_inner(sum_w >>> TRIG_FRAC_BITS);
        n_out.pass = r_pass;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

// ----- hdl/point_rotate_xyz.sv -----
// Top level of the point rotator: configuration registers, stage control and output rounding.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------------
//  input    | in        | i_valid / o_stall     | i_data (in_x, in_y, in_z)
//  output   | out       | o_valid / i_stall     | o_data (out_x, out_y, out_z)
//  config   | in        | i_cfg_wr_en           | i_cfg_index, i_cfg_data
//
// One item enters per cycle while o_stall is low and then passes through the stages:
// one stage scales the height, each of the three rotations takes a multiply stage
// and a sum stage, and the last stage rounds and saturates. Each stage holds while
// the one after it is full and stalled, so empty stages still fill. Reset empties
// the stages and sets the angles to zero and the height factor to one.
module point_rotate_xyz (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  prot_pkg::t_in_item                  i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output prot_pkg::t_out_item                 o_data,
    input  logic                                i_cfg_wr_en,
    input  logic [prot_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic signed [prot_pkg::REG_WIDTH-1:0] i_cfg_data
);
    import prot_pkg::*;

    localparam int NSTAGE = 8;

    logic signed [REG_WIDTH-1:0] r_cos_x, r_sin_x, r_cos_y, r_sin_y;
    logic signed [REG_WIDTH-1:0] r_cos_z, r_sin_z, r_height;

    logic [NSTAGE-1:0] r_valid;
    logic [NSTAGE-1:0] stage_en;

    logic signed [ZPROD_W-1:0] z_prod;
    t_inner    r_x0, r_y0, r_z0;
    t_rot_in   rx_in, ry_in, rz_in;
    t_rot_out  rx_out, ry_out, rz_out;
    t_coef     neg_sin_y;
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_x  <= COS_RESET;
            r_sin_x  <= SIN_RESET;
            r_cos_y  <= COS_RESET;
            r_sin_y  <= SIN_RESET;
            r_cos_z  <= COS_RESET;
            r_sin_z  <= SIN_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_COS_X:  r_cos_x  <= i_cfg_data;
                REG_SIN_X:  r_sin_x  <= i_cfg_data;
                REG_COS_Y:  r_cos_y  <= i_cfg_data;
                REG_SIN_Y:  r_sin_y  <= i_cfg_data;
                REG_COS_Z:  r_cos_z  <= i_cfg_data;
                REG_SIN_Z:  r_sin_z  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        stage_en[NSTAGE-1] = !r_valid[NSTAGE-1] || !i_stall;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k+1];
        end
    end

    assign o_stall = !stage_en[0];
    assign o_valid = r_valid[NSTAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (stage_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign z_prod = i_data.in_z * r_height;

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_x0 <= t_inner'(i_data.in_x) <<< INNER_FRAC;
            r_y0 <= t_inner'(i_data.in_y) <<< INNER_FRAC;
            r_z0 <= clamp_inner(SUM_W'(z_prod));
        end
    end

    assign rx_in     = '{a: r_y0, b: r_z0, pass: r_x0};
    assign neg_sin_y = -t_coef'(r_sin_y);

    prot_rot u_rot_x (
        .i_clk  (i_clk),
        .i_en   ('{mul: stage_en[1], sum: stage_en[2]}),
        .i_data (rx_in),
        .i_cos  (t_coef'(r_cos_x)),
        .i_sin  (t_coef'(r_sin_x)),
        .o_data (rx_out)
    );

    assign ry_in = '{a: rx_out.pass, b: rx_out.w, pass: rx_out.u};

    prot_rot u_rot_y (
        .i_clk  (i_clk),
        .i_en   ('{mul: stage_en[3], sum: stage_en[4]}),
        .i_data (ry_in),
        .i_cos  (t_coef'(r_cos_y)),
        .i_sin  (neg_sin_y),
        .o_data (ry_out)
    );

    assign rz_in = '{a: ry_out.u, b: ry_out.pass, pass: ry_out.w};

    prot_rot u_rot_z (
        .i_clk  (i_clk),
        .i_en   ('{mul: stage_en[5], sum: stage_en[6]}),
        .i_data (rz_in),
        .i_cos  (t_coef'(r_cos_z)),
        .i_sin  (t_coef'(r_sin_z)),
        .o_data (rz_out)
    );

    always_ff @(posedge i_clk) begin
        if (stage_en[NSTAGE-1]) begin
            r_out.out_x <= to_coord(rz_out.u);
            r_out.out_y <= to_coord(rz_out.w);
            r_out.out_z <= to_coord(rz_out.pass);
        end
    end

    assign o_data = r_out;

    // An empty last stage never pushes back on the input.
    a_no_stall_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[NSTAGE-1] |-> !o_stall)
        else $error("input stalled while the last stage is empty");

    // An accepted item occupies the first stage on the next cycle.
    a_accept_fills_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_valid[0])
        else $error("accepted item did not enter the first stage");

    // A full pipeline facing a stalled output must stall the input.
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_valid) && i_stall) |-> o_stall)
        else $error("full pipeline accepted an item while stalled");

    // Reset leaves no result on the output.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

// ----- dv/tb_point_rotate_xyz.sv -----
// Self-checking testbench for the three-axis point rotator with height scaling.
module tb_point_rotate_xyz;
    timeunit 1ns;
    timeprecision 1ps;

    import prot_pkg::*;

    localparam int PIPE_DEPTH     = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(REG_COUNT);
    localparam longint INNER_TOP  = (64'sd1 <<< (INNER_W - 1)) - 64'sd1;
    localparam longint COORD_TOP  = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    t_in_item                    i_data;
    logic                        o_valid;
    logic                        i_stall;
    t_out_item                   o_data;
    logic                        i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic signed [REG_WIDTH-1:0] i_cfg_data;

    logic signed [REG_WIDTH-1:0] coef [REG_COUNT];
    t_out_item                   pending_rotations [$];
    t_out_item                   want;
    bit                          no_idle;
    int                          mismatches;
    int                          points_sent;
    int                          results_seen;
    int                          reg_writes;
    int                          settings_used;
    int                          quiet_cycles;

    point_rotate_xyz dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint sat_inner(input longint v);
        if (v > INNER_TOP) begin
            return INNER_TOP;
        end else if (v < -INNER_TOP - 1) begin
            return -INNER_TOP - 1;
        end
        return v;
    endfunction

    function automatic longint blend(input longint a, input longint p,
                                     input longint b, input longint q);
        longint acc;
        acc = a * p + b * q + (64'sd1 <<< (TRIG_FRAC_BITS - 1));
        return sat_inner(acc >>> TRIG_FRAC_BITS);
    endfunction

    function automatic t_coord round_to_coord(input longint v);
        longint r;
        r = (v + (64'sd1 <<< (INNER_FRAC - 1))) >>> INNER_FRAC;
        if (r > COORD_TOP) begin
            r = COORD_TOP;
        end else if (r < -COORD_TOP - 1) begin
            r = -COORD_TOP - 1;
        end
        return t_coord'(r);
    endfunction

    function automatic t_out_item rotate_point(input t_in_item pt);
        longint px, py, pz, nx, ny, nz;
        longint cx, sx, cy, sy, cz, sz;
        t_out_item r;
        cx = longint'(coef[REG_COS_X]);
        sx = longint'(coef[REG_SIN_X]);
        cy = longint'(coef[REG_COS_Y]);
        sy = longint'(coef[REG_SIN_Y]);
        cz = longint'(coef[REG_COS_Z]);
        sz = longint'(coef[REG_SIN_Z]);
        px = longint'(pt.in_x) * 256;
        py = longint'(pt.in_y) * 256;
        pz = sat_inner(longint'(pt.in_z) * longint'(coef[REG_HEIGHT]));
        ny = blend(py, cx, pz, sx);
        nz = blend(py, -sx, pz, cx);
        py = ny;
        pz = nz;
        nx = blend(px, cy, pz, -sy);
        nz = blend(px, sy, pz, cy);
        px = nx;
        pz = nz;
        nx = blend(px, cz, py, sz);
        ny = blend(px, -sz, py, cz);
        r.out_x = round_to_coord(nx);
        r.out_y = round_to_coord(ny);
        r.out_z = round_to_coord(pz);
        return r;
    endfunction

    function automatic t_in_item mk_point(input int x, input int y, input int z);
        t_in_item pt;
        pt.in_x = t_coord'(x);
        pt.in_y = t_coord'(y);
        pt.in_z = t_coord'(z);
        return pt;
    endfunction

    function automatic t_coord random_coord();
        if ($urandom_range(2) == 0) begin
            return t_coord'($urandom_range(2000) - 1000);
        end
        return t_coord'($urandom);
    endfunction

    function automatic t_in_item random_point();
        t_in_item pt;
        pt.in_x = random_coord();
        pt.in_y = random_coord();
        pt.in_z = random_coord();
        return pt;
    endfunction

    function automatic logic signed [REG_WIDTH-1:0] random_trig(input bit any_pattern);
        if (any_pattern) begin
            return REG_WIDTH'($urandom);
        end
        return REG_WIDTH'(int'($urandom_range(32768)) - 16384);
    endfunction

    task automatic send_point(input t_in_item pt);
        while (!no_idle && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= pt;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        pending_rotations.push_back(rotate_point(pt));
        points_sent++;
    endtask

    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (pending_rotations.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_DEPTH) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic signed [REG_WIDTH-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx < REG_COUNT) begin
            coef[idx] = val;
        end
        reg_writes++;
    endtask

    task automatic load_coefs(input logic signed [REG_WIDTH-1:0] cx, sx, cy, sy, cz, sz, h);
        drain_pipeline();
        write_reg(REG_COS_X, cx);
        write_reg(REG_SIN_X, sx);
        write_reg(REG_COS_Y, cy);
        write_reg(REG_SIN_Y, sy);
        write_reg(REG_COS_Z, cz);
        write_reg(REG_SIN_Z, sz);
        write_reg(REG_HEIGHT, h);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    task automatic send_corners();
        send_point(mk_point(32767, 32767, 32767));
        send_point(mk_point(-32768, -32768, -32768));
        send_point(mk_point(32767, -32768, 32767));
        send_point(mk_point(-32768, 32767, -1));
    endtask

    task automatic test_reset_identity();
        settings_used++;
        send_point(mk_point(0, 0, 0));
        send_corners();
        send_point(mk_point(1, -1, 1));
    endtask

    task automatic test_extreme_coefs();
        load_coefs(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                   -16'sd32768, 16'sd32767, 16'sd32767);
        send_corners();
        load_coefs(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
                   16'sd32767, -16'sd32768, -16'sd32768);
        send_corners();
    endtask

    task automatic test_quarter_turns();
        load_coefs(16'sd0, 16'sd16384, 16'sd0, -16'sd16384,
                   16'sd0, 16'sd16384, 16'sd128);
        send_point(mk_point(100, -200, 300));
        send_point(mk_point(-32768, 0, 32767));
        send_point(mk_point(1, 1, 1));
    endtask

    task automatic test_unmapped_index();
        drain_pipeline();
        write_reg(REG_UNMAPPED, REG_WIDTH'($urandom));
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        send_point(mk_point(12345, -23456, 777));
        send_point(mk_point(-1, 2, -3));
    endtask

    task automatic test_random_angles(input int phases, input int per_phase);
        bit any_pattern;
        logic signed [REG_WIDTH-1:0] h;
        for (int ph = 0; ph < phases; ph++) begin
            any_pattern = (ph % 3 == 2);
            if ($urandom_range(3) == 0) begin
                h = REG_WIDTH'($urandom);
            end else begin
                h = REG_WIDTH'(int'($urandom_range(2048)) - 1024);
            end
            load_coefs(random_trig(any_pattern), random_trig(any_pattern),
                       random_trig(any_pattern), random_trig(any_pattern),
                       random_trig(any_pattern), random_trig(any_pattern), h);
            for (int n = 0; n < per_phase; n++) begin
                send_point(random_point());
            end
        end
    endtask

    task automatic test_full_rate(input int count);
        load_coefs(random_trig(1'b0), random_trig(1'b0), random_trig(1'b0),
                   random_trig(1'b0), random_trig(1'b0), random_trig(1'b0),
                   REG_WIDTH'(int'($urandom_range(1024)) - 512));
        no_idle = 1'b1;
        for (int n = 0; n < count; n++) begin
            send_point(random_point());
        end
        drain_pipeline();
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_rotations.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected result x=%0d y=%0d z=%0d",
                             o_data.out_x, o_data.out_y, o_data.out_z);
                end
            end else begin
                want = pending_rotations.pop_front();
                if (o_data.out_x !== want.out_x || o_data.out_y !== want.out_y ||
                        o_data.out_z !== want.out_z) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                                 want.out_x, want.out_y, want.out_z,
                                 o_data.out_x, o_data.out_y, o_data.out_z);
                    end
                end
            end
        end
        i_stall <= !no_idle && ($urandom_range(99) < 31);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_point_rotate_xyz: done, errors");
            $finish;
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data      <= '0;
        i_stall     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        no_idle     = 1'b0;
        coef[REG_COS_X]  = COS_RESET;
        coef[REG_SIN_X]  = SIN_RESET;
        coef[REG_COS_Y]  = COS_RESET;
        coef[REG_SIN_Y]  = SIN_RESET;
        coef[REG_COS_Z]  = COS_RESET;
        coef[REG_SIN_Z]  = SIN_RESET;
        coef[REG_HEIGHT] = HEIGHT_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_identity();
        test_extreme_coefs();
        test_quarter_turns();
        test_unmapped_index();
        test_random_angles(6, 55);
        test_full_rate(120);

        drain_pipeline();
        $display("Sent %0d points under %0d coefficient settings, checked %0d results.",
                 points_sent, settings_used, results_seen);
        $display("Made %0d register writes, one to an unmapped index; %0d mismatches.",
                 reg_writes, mismatches);
        if (mismatches == 0) begin
            $display("tb_point_rotate_xyz: done, clean");
        end else begin
            $display("tb_point_rotate_xyz: done, errors");
        end
        $finish;
    end

endmodule
